// File: rtl/assert_macros.svh
// Assertion macros for the RTL files that check their own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property sampled on the rising clock edge, switched off while reset is low.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// An implication: when the antecedent holds, the consequent holds next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/harp_pkg.sv
`default_nettype none

package harp_pkg;

	// Position in the range grammar.
	typedef enum logic [3:0] {
		PH_A1_BEGIN = 4'd0,
		PH_A1_ZERO  = 4'd1,
		PH_A1_DIG   = 4'd2,
		PH_GAP1     = 4'd3,
		PH_A2_BEGIN = 4'd4,
		PH_A2_ZERO  = 4'd5,
		PH_A2_DIG   = 4'd6,
		PH_TRAIL    = 4'd7,
		PH_ERR_A1   = 4'd8,
		PH_ERR_SEP  = 4'd9
	} phase_t;

	// Control part of the parse state.
	typedef struct packed {
		phase_t phase;
		logic   digit_seen;
		logic   text_nonempty;
	} ctl_t;

	// Result of decoding one character as a hex digit.
	typedef struct packed {
		logic       hit;
		logic [3:0] val;
	} hex_t;

	localparam int CH_BITS = 16;
	localparam int CFG_BITS = 32;
	localparam int OUT_BITS = 32;
	localparam logic [CFG_BITS-1:0] MAX_ADDRESS_RESET = 32'h0000_FFFF;

	localparam logic [CH_BITS-1:0] CH_DOLLAR = 16'h0024;
	localparam logic [CH_BITS-1:0] CH_LOWER_X = 16'h0078;
	localparam logic [CH_BITS-1:0] CH_ZERO = 16'h0030;
	localparam logic [CH_BITS-1:0] CH_NINE = 16'h0039;
	localparam logic [CH_BITS-1:0] CH_DASH = 16'h002D;
	localparam logic [CH_BITS-1:0] CH_SPACE = 16'h0020;
	localparam logic [CH_BITS-1:0] CH_TAB = 16'h0009;
	localparam logic [CH_BITS-1:0] CH_CR = 16'h000D;
	localparam logic [CH_BITS-1:0] CH_LOWER_A = 16'h0061;
	localparam logic [CH_BITS-1:0] CH_LOWER_F = 16'h0066;
	localparam logic [CH_BITS-1:0] CH_UPPER_A = 16'h0041;
	localparam logic [CH_BITS-1:0] CH_UPPER_F = 16'h0046;
	localparam logic [CH_BITS-1:0] LETTER_OFFSET = 16'h000A;

	// Decodes an ASCII hex digit in either case.
	function automatic hex_t hex_digit(input logic [CH_BITS-1:0] c);
		hex_t r;
		logic [CH_BITS-1:0] diff;
		r = '0;
		diff = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			diff = c - CH_ZERO;
			r.hit = 1'b1;
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
			diff = c - CH_LOWER_A + LETTER_OFFSET;
			r.hit = 1'b1;
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
			diff = c - CH_UPPER_A + LETTER_OFFSET;
			r.hit = 1'b1;
		end
		r.val = diff[3:0];
		return r;
	endfunction

	// ASCII whitespace only: tab to carriage return, and space.
	function automatic logic is_space(input logic [CH_BITS-1:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

`default_nettype wire

// File: rtl/harp_parse.sv
`default_nettype none

// Next parse state for one character of the range text.
module harp_parse #(
	parameter int ADDR_BITS = 32
) (
	input  wire logic [harp_pkg::CH_BITS-1:0] ch,
	input  wire harp_pkg::ctl_t               ctl,
	input  wire logic [ADDR_BITS-1:0]         first_value,
	input  wire logic [ADDR_BITS-1:0]         second_value,
	output harp_pkg::ctl_t                    ctl_next,
	output logic [ADDR_BITS-1:0]              first_next,
	output logic [ADDR_BITS-1:0]              second_next
);

	harp_pkg::hex_t         dig;
	logic                   sp;
	logic [ADDR_BITS-1:0]   dig_w;
	harp_pkg::phase_t       after_first;

	// Character classes.
	always_comb begin
		dig = harp_pkg::hex_digit(ch);
		sp = harp_pkg::is_space(ch);
		dig_w = ADDR_BITS'(dig.val);
	end

	// Phase that follows the first address once a non-digit arrives.
	always_comb begin
		if (sp) begin
			after_first = harp_pkg::PH_GAP1;
		end else if (ch == harp_pkg::CH_DASH) begin
			after_first = harp_pkg::PH_A2_BEGIN;
		end else begin
			after_first = harp_pkg::PH_ERR_SEP;
		end
	end

	// Grammar step.
	always_comb begin
		ctl_next = ctl;
		ctl_next.text_nonempty = 1'b1;
		first_next = first_value;
		second_next = second_value;
		case (ctl.phase)
			harp_pkg::PH_A1_BEGIN: begin
				ctl_next.digit_seen = 1'b0;
				if (ch == harp_pkg::CH_DOLLAR) begin
					ctl_next.phase = harp_pkg::PH_A1_DIG;
				end else if (ch == harp_pkg::CH_ZERO) begin
					ctl_next.phase = harp_pkg::PH_A1_ZERO;
				end else if (dig.hit) begin
					first_next = dig_w;
					ctl_next.digit_seen = 1'b1;
					ctl_next.phase = harp_pkg::PH_A1_DIG;
				end else begin
					ctl_next.phase = harp_pkg::PH_ERR_A1;
				end
			end
			harp_pkg::PH_A2_BEGIN: begin
				if (!sp) begin
					ctl_next.digit_seen = 1'b0;
					if (ch == harp_pkg::CH_DOLLAR) begin
						ctl_next.phase = harp_pkg::PH_A2_DIG;
					end else if (ch == harp_pkg::CH_ZERO) begin
						ctl_next.phase = harp_pkg::PH_A2_ZERO;
					end else if (dig.hit) begin
						second_next = dig_w;
						ctl_next.digit_seen = 1'b1;
						ctl_next.phase = harp_pkg::PH_A2_DIG;
					end else begin
						ctl_next.phase = harp_pkg::PH_ERR_SEP;
					end
				end
			end
			harp_pkg::PH_A1_ZERO: begin
				first_next = '0;
				if (ch == harp_pkg::CH_LOWER_X) begin
					ctl_next.digit_seen = 1'b0;
					ctl_next.phase = harp_pkg::PH_A1_DIG;
				end else begin
					ctl_next.digit_seen = 1'b1;
					if (dig.hit) begin
						first_next = dig_w;
						ctl_next.phase = harp_pkg::PH_A1_DIG;
					end else begin
						ctl_next.phase = after_first;
					end
				end
			end
			harp_pkg::PH_A1_DIG: begin
				if (dig.hit) begin
					first_next = {first_value[ADDR_BITS-5:0], dig.val};
					ctl_next.digit_seen = 1'b1;
				end else if (!ctl.digit_seen) begin
					ctl_next.phase = harp_pkg::PH_ERR_A1;
				end else begin
					ctl_next.phase = after_first;
				end
			end
			harp_pkg::PH_GAP1: begin
				ctl_next.phase = after_first;
			end
			harp_pkg::PH_A2_ZERO: begin
				second_next = '0;
				if (ch == harp_pkg::CH_LOWER_X) begin
					ctl_next.digit_seen = 1'b0;
					ctl_next.phase = harp_pkg::PH_A2_DIG;
				end else begin
					ctl_next.digit_seen = 1'b1;
					if (dig.hit) begin
						second_next = dig_w;
						ctl_next.phase = harp_pkg::PH_A2_DIG;
					end else begin
						ctl_next.phase = harp_pkg::PH_TRAIL;
					end
				end
			end
			harp_pkg::PH_A2_DIG: begin
				if (dig.hit) begin
					second_next = {second_value[ADDR_BITS-5:0], dig.val};
					ctl_next.digit_seen = 1'b1;
				end else if (ctl.digit_seen) begin
					ctl_next.phase = harp_pkg::PH_TRAIL;
				end else begin
					ctl_next.phase = harp_pkg::PH_ERR_SEP;
				end
			end
			default: begin
				ctl_next.phase = ctl.phase;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/harp_result.sv
`default_nettype none

// Final verdict for a finished text: validity, clamp and swap.
module harp_result #(
	parameter int ADDR_BITS = 32
) (
	input  wire harp_pkg::ctl_t                ctl,
	input  wire logic [ADDR_BITS-1:0]          first_value,
	input  wire logic [ADDR_BITS-1:0]          second_value,
	input  wire logic [harp_pkg::CFG_BITS-1:0] max_address,
	output logic                               ok,
	output logic [harp_pkg::OUT_BITS-1:0]      range_start,
	output logic [harp_pkg::OUT_BITS-1:0]      range_end
);

	// Compare width covers both the accumulators and the limit register.
	localparam int CW = (ADDR_BITS > harp_pkg::CFG_BITS) ? ADDR_BITS : harp_pkg::CFG_BITS;

	logic [CW-1:0] first_w;
	logic [CW-1:0] second_w;
	logic [CW-1:0] max_w;
	logic [CW-1:0] s_w;
	logic [CW-1:0] e_w;
	logic [CW-1:0] e_pair;

	always_comb begin
		first_w = CW'(first_value);
		second_w = CW'(second_value);
		max_w = CW'(max_address);
		e_pair = (ctl.phase == harp_pkg::PH_A2_ZERO) ? '0 : second_w;
	end

	// Pick the outcome from the phase the text ended in.
	always_comb begin
		ok = 1'b0;
		s_w = '0;
		e_w = '0;
		if (!ctl.text_nonempty) begin
			ok = 1'b1;
			e_w = max_w;
		end else if (ctl.phase == harp_pkg::PH_A1_ZERO || ctl.phase == harp_pkg::PH_GAP1
				|| (ctl.phase == harp_pkg::PH_A1_DIG && ctl.digit_seen)) begin
			// A single address.
			ok = 1'b1;
			s_w = (ctl.phase == harp_pkg::PH_A1_ZERO) ? '0 : first_w;
			e_w = s_w;
		end else if (ctl.phase == harp_pkg::PH_A2_ZERO
				|| (ctl.phase == harp_pkg::PH_A2_DIG && ctl.digit_seen)) begin
			// A complete pair: check start, clamp end, order the two.
			s_w = first_w;
			e_w = e_pair;
			if (first_w <= max_w) begin
				ok = 1'b1;
				if (e_pair > max_w) begin
					e_w = max_w;
				end else if (e_pair < first_w) begin
					s_w = e_pair;
					e_w = first_w;
				end
			end
		end else if (ctl.phase == harp_pkg::PH_TRAIL) begin
			s_w = first_w;
			e_w = second_w;
		end else if (ctl.phase == harp_pkg::PH_A2_BEGIN || ctl.phase == harp_pkg::PH_A2_DIG
				|| ctl.phase == harp_pkg::PH_ERR_SEP) begin
			s_w = first_w;
		end
	end

	assign range_start = s_w[harp_pkg::OUT_BITS-1:0];
	assign range_end = e_w[harp_pkg::OUT_BITS-1:0];

endmodule

`default_nettype wire

// File: rtl/hex_address_range_parser.sv
`default_nettype none

`include "assert_macros.svh"

// Hex address range parser. The range text arrives one character per item on the
// slave stream, and an item with tlast set ends the text; that end item yields one
// result on the master stream (ok in tuser, start and end addresses in tdata), while
// character items yield none. A text is an address with an optional '$' or '0x'
// prefix, optionally followed by spaces, a '-', spaces and a second address; an empty
// text gives the range from zero to max_address. The block takes one item every
// cycle while no end item is held back: an item waits in the input register, where
// the grammar step and the result logic run in a single pass, and the result of an
// end item appears on the master side at the edge at which it leaves the input
// register. Only a result left waiting on the master side holds an end item back,
// and then no further item is accepted. The limit register is written over the cfg
// channel, which is always ready; the user must write it only while no text is in
// flight, as the block itself does not enforce this. Reset sets it to 0xFFFF.
// Accumulators are ADDR_BITS wide and wrap; reported addresses are their low 32 bits.
module hex_address_range_parser #(
	parameter int ADDR_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: max_address.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,
	// Characters: tdata [15:0] ch; tlast is end_of_text.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,
	input  wire logic        s_tlast,
	// Results: tdata [31:0] range_start, [63:32] range_end; tuser [0] ok.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,
	output logic             m_tuser
);

	logic [harp_pkg::CFG_BITS-1:0] max_address_q;

	logic                          valid_s1;
	logic [harp_pkg::CH_BITS-1:0]  ch_s1;
	logic                          eot_s1;

	harp_pkg::ctl_t                ctl_q;
	logic [ADDR_BITS-1:0]          first_q;
	logic [ADDR_BITS-1:0]          second_q;

	harp_pkg::ctl_t                ctl_next;
	logic [ADDR_BITS-1:0]          first_next;
	logic [ADDR_BITS-1:0]          second_next;

	logic                          res_ok;
	logic [harp_pkg::OUT_BITS-1:0] res_start;
	logic [harp_pkg::OUT_BITS-1:0] res_end;

	logic                          m_valid_q;
	logic                          ok_q;
	logic [harp_pkg::OUT_BITS-1:0] start_q;
	logic [harp_pkg::OUT_BITS-1:0] end_q;

	logic                          out_free;
	logic                          adv;

	// Flow control: character items always leave stage one, end items need the
	// result register free or emptying.
	assign out_free = !m_valid_q || m_tready;
	assign adv = valid_s1 && (!eot_s1 || out_free);
	assign s_tready = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	// Limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_address_q <= harp_pkg::MAX_ADDRESS_RESET;
		end else if (cfg_valid) begin
			max_address_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1 <= s_tdata;
			eot_s1 <= s_tlast;
		end
	end

	harp_parse #(
		.ADDR_BITS(ADDR_BITS)
	) u_parse (
		.ch          (ch_s1),
		.ctl         (ctl_q),
		.first_value (first_q),
		.second_value(second_q),
		.ctl_next    (ctl_next),
		.first_next  (first_next),
		.second_next (second_next)
	);

	harp_result #(
		.ADDR_BITS(ADDR_BITS)
	) u_result (
		.ctl         (ctl_q),
		.first_value (first_q),
		.second_value(second_q),
		.max_address (max_address_q),
		.ok          (res_ok),
		.range_start (res_start),
		.range_end   (res_end)
	);

	// Parse state: advanced by characters, cleared by the end item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '{phase: harp_pkg::PH_A1_BEGIN, digit_seen: 1'b0, text_nonempty: 1'b0};
			first_q <= '0;
			second_q <= '0;
		end else if (adv) begin
			if (eot_s1) begin
				ctl_q <= '{phase: harp_pkg::PH_A1_BEGIN, digit_seen: 1'b0,
					text_nonempty: 1'b0};
				first_q <= '0;
				second_q <= '0;
			end else begin
				ctl_q <= ctl_next;
				first_q <= first_next;
				second_q <= second_next;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv && eot_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && eot_s1) begin
			ok_q <= res_ok;
			start_q <= res_start;
			end_q <= res_end;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {end_q, start_q};
	assign m_tuser = ok_q;

	// A character item never produces a result.
	`ASSERT_NEXT(a_char_no_result, valid_s1 && !eot_s1 && !m_valid_q, !m_valid_q,
		"character item produced a result")

	// Once an end item is consumed the grammar starts afresh.
	`ASSERT_NEXT(a_end_clears, adv && eot_s1,
		ctl_q.phase == harp_pkg::PH_A1_BEGIN && !ctl_q.text_nonempty && !ctl_q.digit_seen,
		"parse state not cleared after end item")

	// An end item may only move on when its result has somewhere to go.
	`ASSERT_CLK(a_no_overwrite, !(adv && eot_s1 && m_valid_q && !m_tready),
		"pending result overwritten")

endmodule

`default_nettype wire
